// ===== hw/rtl/lcnc_pkg.sv =====
// Shared types, constants and helper functions of the card number classifier.
`default_nettype none
package lcnc_pkg;

  localparam int IN_W           = 64;
  localparam int NUM_DIGITS     = 20;   // decimal digits that a 64-bit value can hold
  localparam int MAX_DIGITS     = 19;
  localparam int BITS_PER_STAGE = 4;
  localparam int DD_STAGES      = IN_W / BITS_PER_STAGE;
  localparam int DIG_W          = NUM_DIGITS * 4;
  localparam int GROUPS         = 4;
  localparam int GROUP_LEN      = NUM_DIGITS / GROUPS;
  localparam int GROUP_W        = 6;    // up to five digits of at most 9
  localparam int TOTAL_W        = 8;    // up to twenty digits of at most 9
  localparam int CNT_W          = 5;
  localparam int OUT_W          = 8;

  localparam logic [3:0]       DIG_THREE = 4'd3;
  localparam logic [3:0]       DIG_FOUR  = 4'd4;
  localparam logic [3:0]       DIG_FIVE  = 4'd5;
  localparam logic [3:0]       DIG_SEVEN = 4'd7;
  localparam logic [3:0]       DIG_ONE   = 4'd1;
  localparam logic [3:0]       DIG_NINE  = 4'd9;
  localparam logic [CNT_W-1:0] LEN_13    = 5'd13;
  localparam logic [CNT_W-1:0] LEN_15    = 5'd15;
  localparam logic [CNT_W-1:0] LEN_16    = 5'd16;
  localparam logic [CNT_W-1:0] LEN_MAX   = CNT_W'(MAX_DIGITS);

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  typedef enum logic [1:0] {
    BRAND_NONE = 2'd0,
    BRAND_AX   = 2'd1,
    BRAND_MC   = 2'd2,
    BRAND_VS   = 2'd3
  } brand_t;

  typedef struct packed {
    logic [3:0]       residue;
    logic [CNT_W-1:0] count;
    logic [3:0]       lead;
    logic [3:0]       next;
  } lcnc_sum_t;

  // One double-dabble step: correct every digit, then shift the new bit in.
  function automatic digits_t dd_step(input digits_t bcd, input logic b);
    digits_t          tmp;
    logic [DIG_W-1:0] flat;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      tmp[d] = (bcd[d] >= DIG_FIVE) ? bcd[d] + DIG_THREE : bcd[d];
    end
    flat = tmp;
    return digits_t'({flat[DIG_W-2:0], b});
  endfunction

  // Luhn weight of one digit; every second digit from the right is doubled and folded.
  function automatic logic [3:0] luhn_val(input logic [3:0] d, input logic dbl);
    logic [4:0] twice;
    twice = {d, 1'b0};
    if (!dbl) begin
      return d;
    end
    return (twice > 5'd9) ? 4'(twice - 5'd9) : twice[3:0];
  endfunction

  // Remainder by ten of a small sum through a reciprocal multiply.
  function automatic logic [3:0] mod10(input logic [TOTAL_W-1:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  qt;
    prod = {8'd0, v} * 16'd205;
    q    = prod[15:11];
    qt   = {3'd0, q} * 8'd10;
    return 4'(v - qt);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/luhn_card_number_classifier_unit.sv =====
// Top level of the card number classifier pipeline.
// Takes one card number per beat as a 64-bit unsigned integer and returns its
// brand code, Luhn verdict and decimal digit count. The pipeline accepts one
// beat every cycle while the output is not stalled; each number passes through
// sixteen binary-to-decimal stages (four bits each), two Luhn sum stages and
// the final classification register. A stall on the output holds the whole
// pipeline in place, so in_tready follows out_tready whenever a result is waiting.
// Brand codes: 0 none, 1 prefix 34/37 with 15 digits, 2 prefix 51-55 with
// 16 digits, 3 prefix 4 with 13 or 16 digits. A number longer than 19 digits
// reports checksum_ok 0.
`default_nettype none
module luhn_card_number_classifier_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] card_number
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [1:0] brand, [2] checksum_ok, [7:3] digit_count
);

  logic                                en;
  logic [lcnc_pkg::DD_STAGES:0]        dd_valid;
  logic [lcnc_pkg::IN_W-1:0]           dd_bin [lcnc_pkg::DD_STAGES+1];
  lcnc_pkg::digits_t                   dd_bcd [lcnc_pkg::DD_STAGES+1];
  logic                                sum_valid;
  lcnc_pkg::lcnc_sum_t                 sum;

  // Advance the whole pipeline unless a finished result is held.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign dd_valid[0] = in_tvalid;
  assign dd_bin[0]   = in_tdata;
  assign dd_bcd[0]   = '0;

  for (genvar s = 0; s < lcnc_pkg::DD_STAGES; s++) begin : g_dd
    lcnc_dd_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dd_valid[s]),
      .in_bin    (dd_bin[s]),
      .in_bcd    (dd_bcd[s]),
      .out_valid (dd_valid[s+1]),
      .out_bin   (dd_bin[s+1]),
      .out_bcd   (dd_bcd[s+1])
    );
  end

  lcnc_luhn u_luhn (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dd_valid[lcnc_pkg::DD_STAGES]),
    .in_bcd    (dd_bcd[lcnc_pkg::DD_STAGES]),
    .out_valid (sum_valid),
    .out_sum   (sum)
  );

  lcnc_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sum_valid),
    .in_sum    (sum),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/lcnc_dd_stage.sv =====
// One pipeline stage of the binary to decimal conversion: four shift-and-correct steps.
`default_nettype none
module lcnc_dd_stage (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [lcnc_pkg::IN_W-1:0] in_bin,
  input  wire lcnc_pkg::digits_t     in_bcd,
  output logic                       out_valid,
  output logic [lcnc_pkg::IN_W-1:0]  out_bin,
  output lcnc_pkg::digits_t          out_bcd
);

  logic                         valid_r;
  logic [lcnc_pkg::IN_W-1:0]    bin_r, bin_nxt;
  lcnc_pkg::digits_t            bcd_r, bcd_nxt;

  always_comb begin
    bcd_nxt = in_bcd;
    for (int i = 0; i < lcnc_pkg::BITS_PER_STAGE; i++) begin
      bcd_nxt = lcnc_pkg::dd_step(bcd_nxt, in_bin[lcnc_pkg::IN_W-1-i]);
    end
    bin_nxt = in_bin << lcnc_pkg::BITS_PER_STAGE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_bin   = bin_r;
  assign out_bcd   = bcd_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lcnc_luhn.sv =====
// Luhn sum and leading digit search over the decimal digits, two register stages.
`default_nettype none
module lcnc_luhn (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire lcnc_pkg::digits_t  in_bcd,
  output logic                    out_valid,
  output lcnc_pkg::lcnc_sum_t     out_sum
);

  logic [lcnc_pkg::GROUPS-1:0][lcnc_pkg::GROUP_W-1:0] grp_r, grp_nxt;
  logic [lcnc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]                 lead_r, lead_nxt, next_r, next_nxt;
  logic                       v1_r, v2_r;
  lcnc_pkg::lcnc_sum_t        sum_r, sum_nxt;
  logic [lcnc_pkg::TOTAL_W-1:0] total;

  // Stage 1: group sums, the highest nonzero digit, the digit count and the digit below it.
  always_comb begin
    grp_nxt  = '0;
    cnt_nxt  = '0;
    lead_nxt = '0;
    next_nxt = '0;
    for (int g = 0; g < lcnc_pkg::GROUPS; g++) begin
      for (int k = 0; k < lcnc_pkg::GROUP_LEN; k++) begin
        grp_nxt[g] = grp_nxt[g] + lcnc_pkg::GROUP_W'(lcnc_pkg::luhn_val(
                       in_bcd[g*lcnc_pkg::GROUP_LEN+k],
                       ((g*lcnc_pkg::GROUP_LEN+k) % 2) == 1));
      end
    end
    for (int i = 0; i < lcnc_pkg::NUM_DIGITS; i++) begin
      if (in_bcd[i] != 4'd0) begin
        cnt_nxt  = lcnc_pkg::CNT_W'(i + 1);
        lead_nxt = in_bcd[i];
        next_nxt = (i > 0) ? in_bcd[(i > 0) ? i - 1 : 0] : 4'd0;
      end
    end
  end

  // Stage 2: total and remainder by ten.
  always_comb begin
    total = '0;
    for (int g = 0; g < lcnc_pkg::GROUPS; g++) begin
      total = total + lcnc_pkg::TOTAL_W'(grp_r[g]);
    end
    sum_nxt.residue = lcnc_pkg::mod10(total);
    sum_nxt.count   = cnt_r;
    sum_nxt.lead    = lead_r;
    sum_nxt.next    = next_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r  <= grp_nxt;
      cnt_r  <= cnt_nxt;
      lead_r <= lead_nxt;
      next_r <= next_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_sum   = sum_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lcnc_classify.sv =====
// Final stage: checksum verdict, brand lookup and the output register.
`default_nettype none
module lcnc_classify (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire lcnc_pkg::lcnc_sum_t in_sum,
  output logic                     out_valid,
  output logic [lcnc_pkg::OUT_W-1:0] out_data
);

  logic                         valid_r;
  logic [lcnc_pkg::OUT_W-1:0]   data_r, data_nxt;
  logic                         ok;
  lcnc_pkg::brand_t             brand;

  always_comb begin
    ok    = (in_sum.residue == 4'd0) && (in_sum.count <= lcnc_pkg::LEN_MAX);
    brand = lcnc_pkg::BRAND_NONE;
    if (ok) begin
      priority if (in_sum.lead == lcnc_pkg::DIG_THREE &&
                   (in_sum.next == lcnc_pkg::DIG_FOUR || in_sum.next == lcnc_pkg::DIG_SEVEN) &&
                   in_sum.count == lcnc_pkg::LEN_15) begin
        brand = lcnc_pkg::BRAND_AX;
      end else if (in_sum.lead == lcnc_pkg::DIG_FIVE && in_sum.next >= lcnc_pkg::DIG_ONE &&
                   in_sum.next <= lcnc_pkg::DIG_FIVE && in_sum.count == lcnc_pkg::LEN_16) begin
        brand = lcnc_pkg::BRAND_MC;
      end else if (in_sum.lead == lcnc_pkg::DIG_FOUR &&
                   (in_sum.count == lcnc_pkg::LEN_13 || in_sum.count == lcnc_pkg::LEN_16)) begin
        brand = lcnc_pkg::BRAND_VS;
      end else begin
        brand = lcnc_pkg::BRAND_NONE;
      end
    end
    data_nxt = {in_sum.count, ok, brand};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire
